### hdl/servo_reply_frame_parser_top_assert.svh
// Assertion macros for the servo reply frame parser.
`ifndef SERVO_REPLY_FRAME_PARSER_TOP_ASSERT_SVH
`define SERVO_REPLY_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRFP_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRFP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/srfp_pkg.sv
// Shared types and constants of the servo reply frame parser.
package srfp_pkg;

  localparam logic [7:0] HEAD_BYTE    = 8'hFE;
  localparam logic [7:0] VERSION_BYTE = 8'hCA;
  localparam logic [7:0] END_BYTE     = 8'h0A;
  localparam logic [7:0] LV_PAY0      = 8'h0A;
  localparam logic [7:0] LV_PAY1      = 8'h02;
  localparam int         PAYLOAD_LEN  = 4;
  localparam int         CNT_W        = $clog2(PAYLOAD_LEN + 1);
  localparam int         IDX_W        = $clog2(PAYLOAD_LEN);

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_DECODE_ERR = 2'd1;
  localparam logic [1:0] STATUS_SERVO_ERR  = 2'd2;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_LIMIT      = 3'd0,
    CFG_BROADCAST_ID  = 3'd1,
    CFG_EXCLUDED_ID_A = 3'd2,
    CFG_EXCLUDED_ID_B = 3'd3,
    CFG_LOW_VOLT_CODE = 3'd4,
    CFG_ERROR_OFFSET  = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_HEAD    = 3'd0,
    PH_VERSION = 3'd1,
    PH_ID      = 3'd2,
    PH_CODE    = 3'd3,
    PH_DATA    = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] id_limit;
    logic [7:0] broadcast_id;
    logic [7:0] excluded_id_a;
    logic [7:0] excluded_id_b;
    logic [7:0] low_volt_code;
    logic [7:0] error_offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [7:0]                   reply_id;
    logic [7:0]                   reply_code;
    logic [PAYLOAD_LEN-1:0][7:0]  payload;
    logic signed [15:0]           word_value;
    logic [7:0]                   error_number;
  } result_t;

endpackage

### hdl/servo_reply_frame_parser_top.sv
// Top level of the servo reply frame parser: configuration, decoder and output stage.
// Servo reply frame parser. Takes one received byte per request on the input
// channel and recognizes ten-byte frames: head 0xFE, version 0xCA, servo id,
// code, four payload bytes, 8-bit additive checksum over bytes 1 to 7, end
// 0x0A. Bytes outside a frame are dropped without a result. A bad version,
// id, checksum or end byte gives one decode-error request (status 1, other
// fields zero) and a return to head search. A good frame gives one request
// with id, code, payload and the signed little-endian word of payload bytes
// 0 and 1; a low-voltage code with a payload other than 0x0A,0x02 reports a
// decode error, and any other code at or above error_offset reports status 2
// with error_number = code - error_offset. Rate: one byte per clock while
// in_ready is high; the decoder state machine updates at the edge that takes
// a byte, and the result of that byte is written at the same edge into the
// output register, or into the skid register when the output is stalled. A two-entry
// output stage (output register plus skid register) keeps bytes flowing while
// a result waits; in_ready drops only when both entries hold results. Configuration registers
// are written through cfg_write_en/cfg_index/cfg_wdata and must only be
// changed while the parser is idle; unknown indexes are ignored.
module servo_reply_frame_parser_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write_en,
  input  logic [srfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata,
  // byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     rx_byte,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [7:0]                     reply_id,
  output logic [7:0]                     reply_code,
  output logic [7:0]                     payload_0,
  output logic [7:0]                     payload_1,
  output logic [7:0]                     payload_2,
  output logic [7:0]                     payload_3,
  output logic signed [15:0]             word_value,
  output logic [7:0]                     error_number
);
  import srfp_pkg::*;
  `include "servo_reply_frame_parser_top_assert.svh"

  cfg_t    cfg;
  logic    in_fire;
  logic    res_valid;
  result_t res;
  logic    push;
  logic    out_take;

  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  // Configuration registers: hold until written; ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.id_limit      <= 8'd14;
      cfg.broadcast_id  <= 8'd0;
      cfg.excluded_id_a <= 8'd1;
      cfg.excluded_id_b <= 8'd8;
      cfg.low_volt_code <= 8'd0;
      cfg.error_offset  <= 8'd128;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_ID_LIMIT:      cfg.id_limit      <= cfg_wdata;
        CFG_BROADCAST_ID:  cfg.broadcast_id  <= cfg_wdata;
        CFG_EXCLUDED_ID_A: cfg.excluded_id_a <= cfg_wdata;
        CFG_EXCLUDED_ID_B: cfg.excluded_id_b <= cfg_wdata;
        CFG_LOW_VOLT_CODE: cfg.low_volt_code <= cfg_wdata;
        CFG_ERROR_OFFSET:  cfg.error_offset  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept bytes whenever the skid entry is free; a result can always land.
  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  srfp_frame_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign push     = res_valid;  // res_valid already qualified by in_fire
  assign out_take = out_valid && out_ready;

  // Output stage: the skid entry refills the output register first; a new
  // result goes to the output register when it is free or being drained,
  // otherwise park it in the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (!out_valid || out_ready) begin
        out_valid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_reg <= skid_reg;
      end
    end else if (!out_valid || out_ready) begin
      if (push) begin
        out_reg <= res;
      end
    end else if (push) begin
      skid_reg <= res;
    end
  end

  assign status       = out_reg.status;
  assign reply_id     = out_reg.reply_id;
  assign reply_code   = out_reg.reply_code;
  assign payload_0    = out_reg.payload[0];
  assign payload_1    = out_reg.payload[1];
  assign payload_2    = out_reg.payload[2];
  assign payload_3    = out_reg.payload[3];
  assign word_value   = out_reg.word_value;
  assign error_number = out_reg.error_number;

  // The skid entry only fills behind a full output register.
  `SRFP_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full with output empty")
  // A result arriving at a stalled output register must be parked.
  `SRFP_ASSERT_NEXT(a_park_on_stall, clk, rst, out_valid && !out_ready && !skid_valid && push, skid_valid && out_valid, "result lost on stall")
  // Draining with a parked result refills the output and frees the skid entry.
  `SRFP_ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && out_ready, out_valid && !skid_valid, "skid entry not drained")
  // A presented result never carries an unused status code.
  `SRFP_ASSERT_NOW(a_status_code, clk, rst, out_valid, status == STATUS_OK || status == STATUS_DECODE_ERR || status == STATUS_SERVO_ERR, "bad status code")

endmodule

### hdl/srfp_frame_decoder.sv
// Per-byte frame state machine: tracks the frame and forms one result per finished or broken frame.
module srfp_frame_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  input  srfp_pkg::cfg_t    cfg,
  output logic              res_valid,
  output srfp_pkg::result_t res
);
  import srfp_pkg::*;

  phase_t                      phase, phase_next;
  logic [7:0]                  running_sum, running_sum_next;
  logic [CNT_W-1:0]            payload_count, payload_count_next;
  logic [PAYLOAD_LEN-1:0][7:0] payload_store, payload_store_next;
  logic [7:0]                  held_id, held_id_next;
  logic [7:0]                  held_code, held_code_next;

  logic id_ok;
  logic data_phase_full;
  logic frame_done;
  logic frame_bad;

  assign id_ok = (rx_byte < cfg.id_limit) && (rx_byte != cfg.broadcast_id)
              && (rx_byte != cfg.excluded_id_a) && (rx_byte != cfg.excluded_id_b);
  assign data_phase_full = (payload_count == CNT_W'(PAYLOAD_LEN));

  // Next state and datapath
  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    payload_count_next = payload_count;
    payload_store_next = payload_store;
    held_id_next       = held_id;
    held_code_next     = held_code;
    unique case (phase)
      PH_HEAD: begin
        if (rx_byte == HEAD_BYTE) begin
          phase_next         = PH_VERSION;
          running_sum_next   = '0;
          payload_count_next = '0;
          payload_store_next = '0;
        end
      end
      PH_VERSION: begin
        if (rx_byte == VERSION_BYTE) begin
          running_sum_next = running_sum + rx_byte;
          phase_next       = PH_ID;
        end else begin
          phase_next = PH_HEAD;
        end
      end
      PH_ID: begin
        if (id_ok) begin
          held_id_next     = rx_byte;
          running_sum_next = running_sum + rx_byte;
          phase_next       = PH_CODE;
        end else begin
          phase_next = PH_HEAD;
        end
      end
      PH_CODE: begin
        held_code_next   = rx_byte;
        running_sum_next = running_sum + rx_byte;
        phase_next       = PH_DATA;
      end
      PH_DATA: begin
        if (!data_phase_full) begin
          payload_store_next[payload_count[IDX_W-1:0]] = rx_byte;
          running_sum_next   = running_sum + rx_byte;
          payload_count_next = payload_count + CNT_W'(1);
        end else if (rx_byte == running_sum) begin
          running_sum_next = '0;
          phase_next       = PH_END;
        end else begin
          phase_next = PH_HEAD;
        end
      end
      PH_END: begin
        phase_next = PH_HEAD;
      end
      default: begin
        phase_next = PH_HEAD;
      end
    endcase
  end

  // Result forming
  always_comb begin
    frame_done = 1'b0;
    frame_bad  = 1'b0;
    unique case (phase)
      PH_HEAD:    frame_bad = 1'b0;
      PH_VERSION: frame_bad = (rx_byte != VERSION_BYTE);
      PH_ID:      frame_bad = !id_ok;
      PH_CODE:    frame_bad = 1'b0;
      PH_DATA:    frame_bad = data_phase_full && (rx_byte != running_sum);
      PH_END: begin
        frame_done = (rx_byte == END_BYTE);
        frame_bad  = (rx_byte != END_BYTE);
      end
      default:    frame_bad = 1'b1;
    endcase

    res = '0;
    res.status = STATUS_DECODE_ERR;
    if (frame_done) begin
      res.reply_id   = held_id;
      res.reply_code = held_code;
      res.payload    = payload_store;
      res.word_value = {payload_store[1], payload_store[0]};
      priority if (held_code == cfg.low_volt_code) begin
        // low-voltage alarm must carry its fixed payload
        res.status = STATUS_OK;
        if (!(payload_store[0] == LV_PAY0 && payload_store[1] == LV_PAY1)) begin
          res        = '0;
          res.status = STATUS_DECODE_ERR;
        end
      end else if (held_code >= cfg.error_offset) begin
        res.status       = STATUS_SERVO_ERR;
        res.error_number = held_code - cfg.error_offset;
      end else begin
        res.status = STATUS_OK;
      end
    end
    res_valid = fire && (frame_done || frame_bad);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      running_sum   <= '0;
      payload_count <= '0;
      payload_store <= '0;
      held_id       <= '0;
      held_code     <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      payload_count <= payload_count_next;
      payload_store <= payload_store_next;
      held_id       <= held_id_next;
      held_code     <= held_code_next;
    end
  end

endmodule

### bench/servo_reply_frame_parser_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the servo reply frame parser: directed frames, register sweeps, random stream, back-pressure.
module servo_reply_frame_parser_top_test;
  import srfp_pkg::*;

  // Kinds of damage a generated frame can carry.
  typedef enum int {
    FLAW_NONE,
    FLAW_VERSION,
    FLAW_CHECKSUM,
    FLAW_END,
    FLAW_CUT
  } flaw_t;

  logic clk;
  logic rst = 1'b1;

  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ID_LIMIT;
  logic [7:0]           cfg_wdata = 8'h00;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [7:0]        reply_id;
  logic [7:0]        reply_code;
  logic [7:0]        payload_0;
  logic [7:0]        payload_1;
  logic [7:0]        payload_2;
  logic [7:0]        payload_3;
  logic signed [15:0] word_value;
  logic [7:0]        error_number;

  servo_reply_frame_parser_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .reply_id     (reply_id),
    .reply_code   (reply_code),
    .payload_0    (payload_0),
    .payload_1    (payload_1),
    .payload_2    (payload_2),
    .payload_3    (payload_3),
    .word_value   (word_value),
    .error_number (error_number)
  );

  // Parser state as the bench predicts it, plus the register values last written.
  cfg_t       reg_copy;
  phase_t     frame_phase;
  logic [7:0] frame_sum;
  int         frame_pay_count;
  logic [7:0] frame_payload [PAYLOAD_LEN];
  logic [7:0] frame_id;
  logic [7:0] frame_code;

  // Replies the parser still owes, oldest first.
  result_t expected_replies [$];

  int fail_count = 0;
  int bytes_sent = 0;
  int in_gap_max = 0;
  int out_gap_max = 0;
  int ready_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Reset values of the registers and of the frame decoder.
  function automatic void reset_prediction();
    reg_copy.id_limit      = 8'd14;
    reg_copy.broadcast_id  = 8'd0;
    reg_copy.excluded_id_a = 8'd1;
    reg_copy.excluded_id_b = 8'd8;
    reg_copy.low_volt_code = 8'd0;
    reg_copy.error_offset  = 8'd128;
    frame_phase     = PH_HEAD;
    frame_sum       = 8'h00;
    frame_pay_count = 0;
    foreach (frame_payload[i]) frame_payload[i] = 8'h00;
    frame_id   = 8'h00;
    frame_code = 8'h00;
  endfunction

  // Advance the frame decoder by one received byte; queue a reply if the byte
  // closes or breaks a frame.
  function automatic void decode_byte(logic [7:0] b);
    result_t rep;
    logic    emit;
    logic    broken;
    rep    = '0;
    emit   = 1'b0;
    broken = 1'b0;
    case (frame_phase)
      PH_HEAD: begin
        if (b == HEAD_BYTE) begin
          frame_phase     = PH_VERSION;
          frame_sum       = 8'h00;
          frame_pay_count = 0;
          foreach (frame_payload[i]) frame_payload[i] = 8'h00;
        end
      end
      PH_VERSION: begin
        if (b == VERSION_BYTE) begin
          frame_sum   = frame_sum + b;
          frame_phase = PH_ID;
        end else begin
          broken = 1'b1;
        end
      end
      PH_ID: begin
        if (b < reg_copy.id_limit && b != reg_copy.broadcast_id &&
            b != reg_copy.excluded_id_a && b != reg_copy.excluded_id_b) begin
          frame_id    = b;
          frame_sum   = frame_sum + b;
          frame_phase = PH_CODE;
        end else begin
          broken = 1'b1;
        end
      end
      PH_CODE: begin
        frame_code  = b;
        frame_sum   = frame_sum + b;
        frame_phase = PH_DATA;
      end
      PH_DATA: begin
        if (frame_pay_count < PAYLOAD_LEN) begin
          frame_payload[frame_pay_count] = b;
          frame_sum       = frame_sum + b;
          frame_pay_count = frame_pay_count + 1;
        end else if (b == frame_sum) begin
          frame_sum   = 8'h00;
          frame_phase = PH_END;
        end else begin
          broken = 1'b1;
        end
      end
      PH_END: begin
        frame_phase = PH_HEAD;
        if (b == END_BYTE) begin
          emit             = 1'b1;
          rep.status       = STATUS_OK;
          rep.reply_id     = frame_id;
          rep.reply_code   = frame_code;
          for (int i = 0; i < PAYLOAD_LEN; i++) rep.payload[i] = frame_payload[i];
          rep.word_value   = {frame_payload[1], frame_payload[0]};
          rep.error_number = 8'h00;
          // Low-voltage code wins over the error offset.
          if (frame_code == reg_copy.low_volt_code) begin
            if (!(frame_payload[0] == LV_PAY0 && frame_payload[1] == LV_PAY1)) broken = 1'b1;
          end else if (frame_code >= reg_copy.error_offset) begin
            rep.status       = STATUS_SERVO_ERR;
            rep.error_number = frame_code - reg_copy.error_offset;
          end
        end else begin
          broken = 1'b1;
        end
      end
      default: broken = 1'b1;
    endcase
    if (broken) begin
      frame_phase = PH_HEAD;
      rep         = '0;
      rep.status  = STATUS_DECODE_ERR;
      emit        = 1'b1;
    end
    if (emit) expected_replies.push_back(rep);
  endfunction

  // Offer one byte, idling first for a random gap. Entered and
  // left at a falling edge; valid stays high when the next byte has no gap.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    repeat (gap) begin
      in_valid = 1'b0;
      rx_byte  = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send one frame built from the given fields, damaged as requested.
  task automatic send_frame(logic [7:0] id, logic [7:0] code, logic [7:0] p0,
                            logic [7:0] p1, logic [7:0] p2, logic [7:0] p3,
                            flaw_t flaw);
    logic [7:0] fb [10];
    logic [7:0] cks;
    int         len;
    cks = VERSION_BYTE + id + code + p0 + p1 + p2 + p3;
    fb  = '{HEAD_BYTE, VERSION_BYTE, id, code, p0, p1, p2, p3, cks, END_BYTE};
    len = 10;
    case (flaw)
      FLAW_VERSION:  fb[1] = VERSION_BYTE ^ 8'($urandom_range(255, 1));
      FLAW_CHECKSUM: fb[8] = cks ^ 8'($urandom_range(255, 1));
      FLAW_END:      fb[9] = END_BYTE ^ 8'($urandom_range(255, 1));
      FLAW_CUT:      len = $urandom_range(9, 2);
      default: ;
    endcase
    for (int i = 0; i < len; i++) send_byte(fb[i]);
  endtask

  // Hold until every owed reply is back and the pipeline has drained.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [7:0] v);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_wdata    = v;
    @(negedge clk);
    cfg_write_en = 1'b0;
    case (idx)
      CFG_ID_LIMIT:      reg_copy.id_limit      = v;
      CFG_BROADCAST_ID:  reg_copy.broadcast_id  = v;
      CFG_EXCLUDED_ID_A: reg_copy.excluded_id_a = v;
      CFG_EXCLUDED_ID_B: reg_copy.excluded_id_b = v;
      CFG_LOW_VOLT_CODE: reg_copy.low_volt_code = v;
      CFG_ERROR_OFFSET:  reg_copy.error_offset  = v;
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [7:0] limit, logic [7:0] bcast, logic [7:0] ex_a,
                           logic [7:0] ex_b, logic [7:0] lv_code, logic [7:0] offset);
    wait_idle();
    write_reg(CFG_ID_LIMIT, limit);
    write_reg(CFG_BROADCAST_ID, bcast);
    write_reg(CFG_EXCLUDED_ID_A, ex_a);
    write_reg(CFG_EXCLUDED_ID_B, ex_b);
    write_reg(CFG_LOW_VOLT_CODE, lv_code);
    write_reg(CFG_ERROR_OFFSET, offset);
  endtask

  // One frame with random content, mostly well formed so that the decoder gets
  // past the id check and through the payload.
  task automatic send_random_frame();
    logic [7:0] id;
    logic [7:0] code;
    logic [7:0] pay [4];
    flaw_t      flaw;
    int         pick;
    // Drop a few stray bytes ahead of the head now and then.
    if ($urandom_range(4, 0) == 0) repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
    if ($urandom_range(4, 0) != 0) id = 8'($urandom_range(int'(reg_copy.id_limit) - 1, 0));
    else id = 8'($urandom);
    pick = $urandom_range(3, 0);
    case (pick)
      0: code = reg_copy.low_volt_code;
      1: code = 8'($urandom_range(255, reg_copy.error_offset));
      default: code = 8'($urandom);
    endcase
    foreach (pay[i]) begin
      case ($urandom_range(5, 0))
        0: pay[i] = 8'h00;
        1: pay[i] = 8'hFF;
        default: pay[i] = 8'($urandom);
      endcase
    end
    if (code == reg_copy.low_volt_code && $urandom_range(2, 0) != 0) begin
      pay[0] = LV_PAY0;
      pay[1] = LV_PAY1;
    end
    if ($urandom_range(9, 0) < 7) flaw = FLAW_NONE;
    else flaw = flaw_t'($urandom_range(4, 1));
    send_frame(id, code, pay[0], pay[1], pay[2], pay[3], flaw);
  endtask

  // Directed frames under the reset register values: extremes of the word,
  // low-voltage replies good and bad, servo errors and bad version, id, checksum and end bytes.
  task automatic test_directed_frames();
    in_gap_max  = 0;
    out_gap_max = 0;
    send_frame(8'd2, 8'h10, 8'h00, 8'h80, 8'hFF, 8'h00, FLAW_NONE);
    send_frame(8'd13, 8'h7F, 8'hFF, 8'h7F, 8'h00, 8'hFF, FLAW_NONE);
    send_frame(8'd3, 8'h00, LV_PAY0, LV_PAY1, 8'h55, 8'hAA, FLAW_NONE);
    send_frame(8'd3, 8'h00, LV_PAY0, 8'h03, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd4, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, FLAW_NONE);
    send_frame(8'd5, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    // Head byte where the version belongs is checked as a version byte.
    send_byte(HEAD_BYTE);
    send_byte(HEAD_BYTE);
    send_frame(8'd8, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd14, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd6, 8'h22, 8'h01, 8'h02, 8'h03, 8'h04, FLAW_CHECKSUM);
    send_frame(8'd7, 8'h23, 8'h01, 8'h02, 8'h03, 8'h04, FLAW_END);
    wait_idle();
  endtask

  // Register sweeps: id boundaries, excluded ids and codes around the offset,
  // including a low-voltage code that sits above the error offset.
  task automatic test_register_extremes();
    in_gap_max  = 2;
    out_gap_max = 2;
    load_regs(8'd255, 8'd255, 8'd0, 8'd254, 8'h90, 8'h00);
    send_frame(8'd253, 8'h90, LV_PAY0, LV_PAY1, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd252, 8'h90, 8'h00, LV_PAY1, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd1, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, FLAW_NONE);
    send_frame(8'd254, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd0, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    load_regs(8'd1, 8'd5, 8'd6, 8'd7, 8'hFF, 8'hFF);
    send_frame(8'd0, 8'hFF, LV_PAY0, LV_PAY1, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd0, 8'hFE, 8'h80, 8'hFF, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    load_regs(8'd20, 8'd19, 8'd3, 8'd3, 8'h40, 8'h41);
    send_frame(8'd19, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd18, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd3, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'd2, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, FLAW_NONE);
    wait_idle();
  endtask

  // Random stream over several register settings, with and without idling.
  task automatic test_random_stream();
    int target;
    for (int setting = 0; setting < 6; setting++) begin
      case (setting)
        0: load_regs(8'd14, 8'd0, 8'd1, 8'd8, 8'd0, 8'd128);
        1: load_regs(8'd255, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0);
        2: load_regs(8'd1, 8'd255, 8'd254, 8'd253, 8'd0, 8'd255);
        default: load_regs(8'($urandom_range(255, 1)), 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      in_gap_max  = (setting % 2 == 0) ? 5 : 0;
      out_gap_max = (setting % 3 == 0) ? 0 : 5;
      target = bytes_sent + 95;
      while (bytes_sent < target) send_random_frame();
    end
    wait_idle();
  endtask

  // Stall the result side for a long stretch while bytes keep coming, so the
  // output stage fills and the input stalls.
  task automatic test_back_pressure();
    load_regs(8'd14, 8'd0, 8'd1, 8'd8, 8'd0, 8'd128);
    in_gap_max        = 0;
    out_gap_max       = 0;
    ready_hold_cycles = 200;
    repeat (20) send_frame(8'($urandom_range(13, 9)), 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom), FLAW_NONE);
    out_gap_max = 5;
    repeat (10) send_random_frame();
    wait_idle();
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result side: draw a stall per reply, take the reply and check it against
  // the oldest owed one.
  initial begin : reply_checker
    result_t want;
    int      stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (ready_hold_cycles > 0) begin
        out_ready = 1'b0;
        repeat (ready_hold_cycles) @(negedge clk);
        ready_hold_cycles = 0;
      end
      stall = $urandom_range(out_gap_max, 0);
      out_ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual status %0d id %0h code %0h",
                 $time, status, reply_id, reply_code);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("status", want.status, status);
        check_field("reply_id", want.reply_id, reply_id);
        check_field("reply_code", want.reply_code, reply_code);
        check_field("payload_0", want.payload[0], payload_0);
        check_field("payload_1", want.payload[1], payload_1);
        check_field("payload_2", want.payload[2], payload_2);
        check_field("payload_3", want.payload[3], payload_3);
        check_field("word_value", want.word_value, word_value);
        check_field("error_number", want.error_number, error_number);
      end
      @(negedge clk);
    end
  end

  // Main sequence: reset, run each test in turn, then drain and report.
  initial begin
    reset_prediction();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_frames();
    test_register_extremes();
    test_random_stream();
    test_back_pressure();
    wait_idle();
    // Leave room for any stray reply to show up before the verdict.
    repeat (10) @(negedge clk);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
